>>> rtl/core/phps_pkg.sv
// Package for the polynomial hash probe set: widths, hash constants, result layout
// and the modular reduction helpers.
// Used by polynomial_hash_probe_set_unit and its testbench; depends on nothing.
`default_nettype none

package phps_pkg;

    // Field widths of the stream items
    localparam int KEY_W   = 8;
    localparam int FIELD_W = 10;
    localparam int OUT_W   = 24;

    // Rolling hash arithmetic
    localparam int HASH_W  = 35;
    localparam int WIDE_W  = 43;
    localparam logic [HASH_W-1:0] HASH_P      = 35'd32416190071;
    // 96 * HASH_P, keeps the running sum non-negative before reduction
    localparam logic [WIDE_W-1:0] HASH_OFFSET = 43'd3111954246816;
    localparam logic signed [8:0] CHAR_OFFSET = 9'sd96;
    localparam int BASE_SHIFT = 6;
    // floor(2^46 / HASH_P); quotient estimate is low by at most one
    localparam logic [11:0] RECIP = 12'd2170;

    // Probe table
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int WALK_LIMIT  = TABLE_SLOTS + 8;
    localparam int STEP_W      = $clog2(WALK_LIMIT);
    localparam int PROBE_SHIFT = 5;

    localparam logic [FIELD_W-1:0] MAX_ENTRIES_RESET = 10'd716;

    typedef enum logic {
        REQ_ADD   = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } slot_t;

    // Packed from the MSB down; found sits in bit 0
    typedef struct packed {
        logic [FIELD_W-1:0] entry_total;
        logic [FIELD_W-1:0] slot_index;
        logic               table_full;
        logic               inserted;
        logic               found;
    } result_t;

    // Estimate floor(y / HASH_P) from the top bits of y
    function automatic logic [8:0] quot_est(input logic [WIDE_W-1:0] y);
        logic [28:0] prod;
        prod = 29'(y[WIDE_W-1:26]) * 29'(RECIP);
        return prod[28:20];
    endfunction

    // Final correction of a remainder known to be below 2 * HASH_P
    function automatic logic [HASH_W-1:0] rem_fix(input logic [HASH_W:0] r);
        logic [HASH_W:0] p_ext;
        p_ext = {1'b0, HASH_P};
        if (r >= p_ext)
        begin
            return HASH_W'(r - p_ext);
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/polynomial_hash_probe_set_unit.sv
// Polynomial hash probe set: rolling hash over streamed key bytes and an
// open-addressing hash table walked with perturbation probing.
// Depends on phps_pkg.
//
//  channel  | dir | signals                            | content
//  ---------+-----+------------------------------------+-------------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser  | key byte, req_type in tuser,
//           |     | s_tlast                            | key_last in tlast
//  m_*      | out | m_tvalid m_tready m_tdata          | one result per key
//  cfg_*    | in  | cfg_wr_en cfg_wr_data              | max_entries
//
//  For each key byte the transfer cycle multiplies and adds, then the
//  modular reduction estimates the quotient, subtracts and corrects.
//  After the last byte ST_START starts the walk, ST_PROBE visits one slot per cycle
//  (one read of the slot memory per cycle) and ST_DONE loads the output register.
//  After reset a clearing pass over all TABLE_SLOTS (1024) slots empties the table;
//  s_tready stays low until it ends. Bytes are still taken while a result waits
//  in the output register; a walk that ends then holds in ST_DONE, s_tready low.
`default_nettype none

module polynomial_hash_probe_set_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [phps_pkg::KEY_W-1:0]     s_tdata,     // [7:0] key_byte
    input  wire logic                           s_tuser,     // [0] req_type
    input  wire logic                           s_tlast,     // key_last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] found, [1] inserted, [2] table_full, [12:3] slot_index,
    // [22:13] entry_total, [23] zero
    output logic [phps_pkg::OUT_W-1:0]          m_tdata,
    input  wire logic                           cfg_wr_en,
    input  wire logic [phps_pkg::FIELD_W-1:0]   cfg_wr_data  // max_entries
);

    import phps_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QEST,
        ST_SUB,
        ST_FIX,
        ST_START,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [FIELD_W-1:0]   max_entries_reg;
    logic [FIELD_W-1:0]   entry_count_reg;
    logic [HASH_W-1:0]    running_reg;
    logic [HASH_W-1:0]    power_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [HASH_W-1:0]    perturb_reg;
    logic                 last_reg;
    req_t                 req_reg;
    logic [WIDE_W-1:0]    y_reg;
    logic [WIDE_W-1:0]    py_reg;
    logic [8:0]           q_reg;
    logic [8:0]           pq_reg;
    logic [HASH_W:0]      r_reg;
    logic [HASH_W:0]      pr_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    clr_idx_reg;
    logic [STEP_W-1:0]    steps_reg;
    result_t              res_reg;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    // Slot memory, one read and one write port
    slot_t                slot_mem [TABLE_SLOTS];
    slot_t                rd_q_reg;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    slot_t                wr_data;

    logic                 s_xfer;
    logic signed [8:0]    letter;
    logic signed [44:0]   prod;
    logic signed [44:0]   sum;
    logic [WIDE_W-1:0]    y_next;
    logic [WIDE_W-1:0]    py_next;
    logic [HASH_W:0]      r_next;
    logic [HASH_W:0]      pr_next;
    logic [HASH_W-1:0]    running_next;
    logic [HASH_W-1:0]    power_next;
    logic [SLOT_W-1:0]    idx_next;
    logic                 hit;
    logic                 empty;
    logic                 walk_end;
    logic                 stop;
    logic                 insert;
    result_t              res_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Hash datapath
    always_comb
    begin
        letter  = $signed({1'b0, s_tdata}) - CHAR_OFFSET;
        prod    = 45'(letter) * 45'($signed({1'b0, power_reg}));
        sum     = prod + 45'($signed({1'b0, running_reg}))
                  + 45'($signed({2'b00, HASH_OFFSET}));
        y_next  = sum[WIDE_W-1:0];
        py_next = WIDE_W'({power_reg, {BASE_SHIFT{1'b0}}});
        r_next  = (HASH_W+1)'(y_reg - WIDE_W'(q_reg * HASH_P));
        pr_next = (HASH_W+1)'(py_reg - WIDE_W'(pq_reg * HASH_P));
        running_next = rem_fix(r_reg);
        power_next   = rem_fix(pr_reg);
    end

    // Probe step decision
    always_comb
    begin
        idx_next = (idx_reg << 2) + idx_reg + perturb_reg[SLOT_W-1:0] + SLOT_W'(1);
        empty    = !rd_q_reg.valid;
        hit      = rd_q_reg.valid && (rd_q_reg.hash == hash_reg);
        walk_end = (steps_reg == STEP_W'(WALK_LIMIT - 1));
        stop     = empty || hit || walk_end;
        insert   = (req_reg == REQ_ADD) && empty && (entry_count_reg < max_entries_reg);

        res_next.found       = hit;
        res_next.inserted    = insert;
        res_next.table_full  = (req_reg == REQ_ADD) && !hit && !insert;
        res_next.slot_index  = FIELD_W'((empty || hit) ? idx_reg : idx_next);
        res_next.entry_total = insert ? entry_count_reg + FIELD_W'(1) : entry_count_reg;
    end

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '{valid: 1'b1, hash: hash_reg};
        rd_addr = hash_reg[SLOT_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '{valid: 1'b0, hash: hash_reg};
            end
            ST_PROBE:
            begin
                wr_en   = stop && insert;
                rd_addr = idx_next;
            end
            ST_IDLE, ST_QEST, ST_SUB, ST_FIX, ST_START, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= slot_mem[rd_addr];
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_entries_reg <= cfg_wr_data;
        end
    end

    // Sequencer, hash state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            entry_count_reg <= '0;
            running_reg     <= '0;
            power_reg       <= HASH_W'(1);
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            // in ST_DONE the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                    if (clr_idx_reg == SLOT_W'(TABLE_SLOTS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_xfer)
                    begin
                        y_reg     <= y_next;
                        py_reg    <= py_next;
                        last_reg  <= s_tlast;
                        req_reg   <= req_t'(s_tuser);
                        state_reg <= ST_QEST;
                    end
                end
                ST_QEST:
                begin
                    q_reg     <= quot_est(y_reg);
                    pq_reg    <= quot_est(py_reg);
                    state_reg <= ST_SUB;
                end
                ST_SUB:
                begin
                    r_reg     <= r_next;
                    pr_reg    <= pr_next;
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    if (last_reg)
                    begin
                        // key complete: latch hash, restart the polynomial
                        hash_reg    <= running_next;
                        running_reg <= '0;
                        power_reg   <= HASH_W'(1);
                        state_reg   <= ST_START;
                    end
                    else
                    begin
                        running_reg <= running_next;
                        power_reg   <= power_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_START:
                begin
                    idx_reg     <= hash_reg[SLOT_W-1:0];
                    perturb_reg <= hash_reg;
                    steps_reg   <= '0;
                    state_reg   <= ST_PROBE;
                end
                ST_PROBE:
                begin
                    if (stop)
                    begin
                        res_reg   <= res_next;
                        if (insert)
                        begin
                            entry_count_reg <= entry_count_reg + FIELD_W'(1);
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        // advance to the next slot; its read is already issued
                        idx_reg     <= idx_next;
                        perturb_reg <= perturb_reg >> PROBE_SHIFT;
                        steps_reg   <= steps_reg + STEP_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= OUT_W'(res_reg);
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_polynomial_hash_probe_set_unit.sv
// Testbench for polynomial_hash_probe_set_unit: streams key bytes, predicts each
// lookup outcome with its own hash table model (or takes a hand-typed one) and checks every result transfer.
// Depends on phps_pkg and the unit under test; self-contained otherwise.

module tb_polynomial_hash_probe_set_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import phps_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int STALL_PCT  = 14;
    localparam int POOL_DEPTH = 64;
    localparam int KEY_MAX    = 24;
    localparam int DRAIN_CYCLES = 64;
    localparam longint HASH_MOD = 64'd32416190071;
    localparam longint unsigned SLOT_MASK = TABLE_SLOTS - 1;

    typedef struct {
        bit                 is_limit;
        req_t               req;
        logic [KEY_W-1:0]   data;
        logic               last;
        bit                 fixed;
        result_t            res;
        logic [FIELD_W-1:0] limit;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [KEY_W-1:0]    s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_wr_en;
    logic [FIELD_W-1:0]  cfg_wr_data;

    // Travels with each byte: a hand-typed outcome replaces the prediction
    bit      row_fixed;
    result_t row_result;
    bit      calm;

    // Model of the hash state and the probe table
    longint  acc_hash;
    longint  acc_power;
    bit      slot_used [TABLE_SLOTS];
    logic [HASH_W-1:0] slot_key [TABLE_SLOTS];
    int      stored_count;
    int      limit_model;
    result_t expected_outcomes [$];

    logic [KEY_W-1:0] pool_bytes [POOL_DEPTH][KEY_MAX];
    int      pool_len [POOL_DEPTH];
    int      pool_n;

    int      mismatches;
    int      n_results;
    int      n_found;
    int      n_inserted;
    int      n_refused;

    polynomial_hash_probe_set_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Fold one byte into the rolling hash; on the last byte walk the table
    function automatic bit fold_key_byte(input req_t r, input logic [KEY_W-1:0] b,
                                         input logic l, output result_t res);
        longint letter;
        longint sum;
        longint unsigned h;
        longint unsigned idx;
        longint unsigned perturb;
        bit hit;
        bit open;
        bit added;
        bit refused;
        letter = longint'(b) - 96;
        sum = (acc_hash + letter * acc_power) % HASH_MOD;
        if (sum < 0)
        begin
            sum += HASH_MOD;
        end
        acc_hash = sum;
        acc_power = (acc_power * 64) % HASH_MOD;
        res = '0;
        if (!l)
        begin
            return 1'b0;
        end
        h = acc_hash;
        acc_hash = 0;
        acc_power = 1;
        idx = h & SLOT_MASK;
        perturb = h;
        hit = 1'b0;
        open = 1'b0;
        added = 1'b0;
        refused = 1'b0;
        for (int n = 0; n < TABLE_SLOTS + 8; n++)
        begin
            if (!slot_used[idx])
            begin
                open = 1'b1;
                break;
            end
            if (slot_key[idx] == h[HASH_W-1:0])
            begin
                hit = 1'b1;
                break;
            end
            idx = (idx * 5 + perturb + 1) & SLOT_MASK;
            perturb >>= 5;
        end
        if (r == REQ_ADD && !hit)
        begin
            if (open && stored_count < limit_model)
            begin
                slot_used[idx] = 1'b1;
                slot_key[idx] = h[HASH_W-1:0];
                stored_count++;
                added = 1'b1;
            end
            else
            begin
                refused = 1'b1;
            end
        end
        res.found = hit;
        res.inserted = added;
        res.table_full = refused;
        res.slot_index = idx[FIELD_W-1:0];
        res.entry_total = FIELD_W'(stored_count);
        return 1'b1;
    endfunction

    function automatic plan_row_t byte_row(input req_t r, input logic [KEY_W-1:0] d,
                                           input logic l);
        plan_row_t row;
        row.is_limit = 1'b0;
        row.req = r;
        row.data = d;
        row.last = l;
        row.fixed = 1'b0;
        row.res = '0;
        row.limit = '0;
        return row;
    endfunction

    function automatic plan_row_t known_row(input req_t r, input logic [KEY_W-1:0] d,
                                            input bit f, input bit i, input bit t,
                                            input int slot, input int total);
        plan_row_t row;
        row = byte_row(r, d, 1'b1);
        row.fixed = 1'b1;
        row.res.found = f;
        row.res.inserted = i;
        row.res.table_full = t;
        row.res.slot_index = FIELD_W'(slot);
        row.res.entry_total = FIELD_W'(total);
        return row;
    endfunction

    function automatic plan_row_t limit_row(input int v);
        plan_row_t row;
        row = byte_row(REQ_ADD, '0, 1'b0);
        row.is_limit = 1'b1;
        row.limit = FIELD_W'(v);
        return row;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input req_t r, input logic [KEY_W-1:0] d, input logic l,
                             input bit f, input result_t res);
        while (!calm && $urandom_range(0, 99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= d;
        s_tuser    <= r;
        s_tlast    <= l;
        row_fixed  <= f;
        row_result <= res;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Hold off until every result is back and the unit has gone quiet
    task automatic write_limit(input logic [FIELD_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        limit_model = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        logic [KEY_W-1:0] key [KEY_MAX];
        int len;
        int sent;
        int pick;
        req_t r;
        sent = 0;
        while (sent < n_items)
        begin
            if (pool_n > 0 && $urandom_range(0, 99) < 40)
            begin
                // revisit a known key so adds and queries hit stored slots
                pick = $urandom_range(0, pool_n - 1);
                len = pool_len[pick];
                for (int k = 0; k < len; k++)
                begin
                    key[k] = pool_bytes[pick][k];
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len = $urandom_range(1, 4);
                end
                else if (pick < 95)
                begin
                    len = $urandom_range(5, 10);
                end
                else
                begin
                    len = $urandom_range(11, KEY_MAX);
                end
                for (int k = 0; k < len; k++)
                begin
                    key[k] = KEY_W'($urandom_range(0, 255));
                end
                pick = (pool_n < POOL_DEPTH) ? pool_n : $urandom_range(0, POOL_DEPTH - 1);
                if (pool_n < POOL_DEPTH)
                begin
                    pool_n++;
                end
                pool_len[pick] = len;
                for (int k = 0; k < len; k++)
                begin
                    pool_bytes[pick][k] = key[k];
                end
            end
            for (int k = 0; k < len; k++)
            begin
                r = req_t'(1'($urandom_range(0, 1)));
                send_byte(r, key[k], k == len - 1, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Check results before predicting, so a same-edge transfer never matches itself
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_outcomes.size() == 0)
                begin
                    $error("result 0x%h arrived with nothing expected", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    compare_field("found", want.found, got.found);
                    compare_field("inserted", want.inserted, got.inserted);
                    compare_field("table_full", want.table_full, got.table_full);
                    compare_field("slot_index", want.slot_index, got.slot_index);
                    compare_field("entry_total", want.entry_total, got.entry_total);
                    n_results++;
                    n_found += want.found;
                    n_inserted += want.inserted;
                    n_refused += want.table_full;
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (fold_key_byte(req_t'(s_tuser), s_tdata, s_tlast, pred))
                begin
                    expected_outcomes.push_back(row_fixed ? row_result : pred);
                end
            end
        end
    end

    initial
    begin
        plan_row_t plan [$];
        int guard;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        row_fixed = 1'b0;
        row_result = '0;
        calm = 1'b0;
        acc_hash = 0;
        acc_power = 1;
        stored_count = 0;
        limit_model = MAX_ENTRIES_RESET;
        pool_n = 0;
        mismatches = 0;
        n_results = 0;
        n_found = 0;
        n_inserted = 0;
        n_refused = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
        end

        // Single-byte keys hash to (byte-96) mod HASH_P, so their slots read off directly
        plan.push_back(known_row(REQ_ADD,   8'd96,  0, 1, 0, 0, 1));
        plan.push_back(known_row(REQ_QUERY, 8'd96,  1, 0, 0, 0, 1));
        plan.push_back(known_row(REQ_ADD,   8'd96,  1, 0, 0, 0, 1));
        plan.push_back(known_row(REQ_QUERY, 8'd97,  0, 0, 0, 1, 1));
        plan.push_back(known_row(REQ_ADD,   8'd0,   0, 1, 0, 535, 2));
        plan.push_back(known_row(REQ_ADD,   8'd255, 0, 1, 0, 159, 3));
        // three-byte key hashes to 14176, home slot 864; type on early bytes is ignored
        plan.push_back(byte_row(REQ_ADD,   8'd0,   1'b0));
        plan.push_back(byte_row(REQ_QUERY, 8'd255, 1'b0));
        plan.push_back(known_row(REQ_ADD,   8'd97,  0, 1, 0, 864, 4));
        plan.push_back(byte_row(REQ_QUERY, 8'd0,   1'b0));
        plan.push_back(byte_row(REQ_ADD,   8'd255, 1'b0));
        plan.push_back(known_row(REQ_QUERY, 8'd97,  1, 0, 0, 864, 4));
        // hash restarts after a key end
        plan.push_back(known_row(REQ_QUERY, 8'd97,  0, 0, 0, 1, 4));
        plan.push_back(limit_row(4));
        plan.push_back(known_row(REQ_ADD,   8'd98,  0, 0, 1, 2, 4));
        plan.push_back(known_row(REQ_QUERY, 8'd98,  0, 0, 0, 2, 4));
        plan.push_back(limit_row(0));
        plan.push_back(known_row(REQ_ADD,   8'd99,  0, 0, 1, 3, 4));
        plan.push_back(known_row(REQ_ADD,   8'd96,  1, 0, 0, 0, 4));
        plan.push_back(limit_row(1023));
        plan.push_back(known_row(REQ_ADD,   8'd98,  0, 1, 0, 2, 5));
        plan.push_back(byte_row(REQ_ADD, 8'd255, 1'b0));
        plan.push_back(byte_row(REQ_ADD, 8'd255, 1'b0));
        plan.push_back(byte_row(REQ_ADD, 8'd255, 1'b0));
        plan.push_back(byte_row(REQ_ADD, 8'd255, 1'b1));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_limit)
            begin
                write_limit(plan[i].limit);
            end
            else
            begin
                send_byte(plan[i].req, plan[i].data, plan[i].last, plan[i].fixed,
                          plan[i].res);
            end
        end

        run_random(300);
        write_limit(FIELD_W'(stored_count + $urandom_range(2, 8)));
        run_random(150);
        write_limit('0);
        run_random(100);
        write_limit(FIELD_W'($urandom_range(1, 1023)));
        run_random(150);
        write_limit(10'd1023);
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;
        run_random(150);

        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_outcomes.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", expected_outcomes.size());
            mismatches++;
        end

        $display("checked %0d lookups: %0d hits, %0d new entries, %0d adds refused",
                 n_results, n_found, n_inserted, n_refused);
        $display("entry limits 0 to 1023 exercised, %0d keys stored at the end",
                 stored_count);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> polynomial_hash_probe_set_unit.f
rtl/core/phps_pkg.sv
rtl/core/polynomial_hash_probe_set_unit.sv
bench/tb_polynomial_hash_probe_set_unit.sv
